// ===== rtl/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, constants and the microcode ROM for the biquad cascade.
// ----------------------------------------------------------------------------
package cbq_pkg;

    localparam int MAX_STAGES      = 8;
    localparam int COEFS_PER_STAGE = 5;
    localparam int DATA_W          = 16;
    localparam int ACC_W           = 32;
    localparam int STAGE_W         = $clog2(MAX_STAGES);
    localparam int NSTG_W          = $clog2(MAX_STAGES + 1);
    localparam int SLOT_W          = 3;
    localparam int COEF_DEPTH      = MAX_STAGES * COEFS_PER_STAGE;
    localparam int CADDR_W         = $clog2(COEF_DEPTH);
    localparam int PC_W            = 4;

    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_A0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd4;

    // program steps
    localparam logic [PC_W-1:0] PC_CHECK   = 4'd0;
    localparam logic [PC_W-1:0] PC_RD_A0   = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL_X   = 4'd2;
    localparam logic [PC_W-1:0] PC_MUL_XH0 = 4'd3;
    localparam logic [PC_W-1:0] PC_RD_A2   = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL_XH1 = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL_YH0 = 4'd6;
    localparam logic [PC_W-1:0] PC_RD_B2   = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL_YH1 = 4'd8;
    localparam logic [PC_W-1:0] PC_SUB_B2  = 4'd9;
    localparam logic [PC_W-1:0] PC_WB      = 4'd10;
    localparam logic [PC_W-1:0] PC_DONE    = 4'd11;

    localparam logic [2:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [NSTG_W-1:0] STAGE_COUNT_RST = NSTG_W'(2);

    typedef enum logic [2:0] {
        OPD_X,
        OPD_XH0,
        OPD_XH1,
        OPD_YH0,
        OPD_YH1
    } opd_sel_t;

    typedef enum logic [1:0] {
        ACC_NOP,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_ZERO,
        JC_MORE,
        JC_WAIT
    } jcond_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              mul_en;
        opd_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              wb;
        logic              out_ld;
        jcond_t            jcond;
        logic [PC_W-1:0]   jtarget;
    } ucode_t;

    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_slot;
        logic               mul_en;
        opd_sel_t           mul_sel;
        acc_op_t            acc_op;
        logic               wb;
        logic               out_ld;
        logic [STAGE_W-1:0] stage;
    } ctl_t;

    typedef struct packed {
        logic                     en;
        logic [CADDR_W-1:0]       addr;
        logic signed [DATA_W-1:0] data;
    } coef_wr_t;

    function automatic logic [CADDR_W-1:0] coef_addr(input logic [STAGE_W-1:0] stage,
                                                     input logic [SLOT_W-1:0] slot);
        coef_addr = CADDR_W'(stage) * CADDR_W'(COEFS_PER_STAGE) + CADDR_W'(slot);
    endfunction

    // one stage: read coef, multiply the next cycle, accumulate the cycle after
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = '0;
        case (pc)
            PC_CHECK:
            begin
                u.jcond   = JC_ZERO;
                u.jtarget = PC_DONE;
            end
            PC_RD_A0:
            begin
                u.rd_en   = 1'b1;
                u.rd_slot = SLOT_A0;
            end
            PC_MUL_X:
            begin
                u.rd_en   = 1'b1;
                u.rd_slot = SLOT_A1;
                u.mul_en  = 1'b1;
                u.mul_sel = OPD_X;
            end
            PC_MUL_XH0:
            begin
                u.mul_en  = 1'b1;
                u.mul_sel = OPD_XH0;
                u.acc_op  = ACC_LOAD;
            end
            PC_RD_A2:
            begin
                u.rd_en   = 1'b1;
                u.rd_slot = SLOT_A2;
                u.acc_op  = ACC_ADD;
            end
            PC_MUL_XH1:
            begin
                u.rd_en   = 1'b1;
                u.rd_slot = SLOT_B1;
                u.mul_en  = 1'b1;
                u.mul_sel = OPD_XH1;
                u.acc_op  = ACC_ADD;
            end
            PC_MUL_YH0:
            begin
                u.mul_en  = 1'b1;
                u.mul_sel = OPD_YH0;
                u.acc_op  = ACC_ADD;
            end
            PC_RD_B2:
            begin
                u.rd_en   = 1'b1;
                u.rd_slot = SLOT_B2;
                u.acc_op  = ACC_SUB;
            end
            PC_MUL_YH1:
            begin
                u.mul_en  = 1'b1;
                u.mul_sel = OPD_YH1;
                u.acc_op  = ACC_SUB;
            end
            PC_SUB_B2:
            begin
                u.acc_op  = ACC_SUB;
            end
            PC_WB:
            begin
                u.wb      = 1'b1;
                u.jcond   = JC_MORE;
                u.jtarget = PC_RD_A0;
            end
            PC_DONE:
            begin
                u.out_ld  = 1'b1;
                u.jcond   = JC_WAIT;
                u.jtarget = PC_DONE;
            end
            default:
            begin
                u = '0;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/cbq_sequencer.sv =====
// ----------------------------------------------------------------------------
// cbq_sequencer
// Step counter, stage counter and microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module cbq_sequencer
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cbq_pkg::NSTG_W-1:0] n_stages,
    input  logic                       out_free,
    output cbq_pkg::ctl_t              ctl,
    output logic                       busy
);
    import cbq_pkg::*;

    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic               busy_reg, busy_next;
    logic               last_stage;
    ucode_t             uw;

    assign uw         = ucode_rom(pc_reg);
    assign last_stage = (NSTG_W'(stage_reg) == n_stages - NSTG_W'(1));
    assign busy       = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_CHECK;
            stage_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            stage_reg <= stage_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        pc_next    = pc_reg;
        stage_next = stage_reg;
        busy_next  = busy_reg;
        ctl        = '0;
        if (start)
        begin
            busy_next  = 1'b1;
            pc_next    = PC_CHECK;
            stage_next = '0;
        end
        else if (busy_reg)
        begin
            ctl.rd_en   = uw.rd_en;
            ctl.rd_slot = uw.rd_slot;
            ctl.mul_en  = uw.mul_en;
            ctl.mul_sel = uw.mul_sel;
            ctl.acc_op  = uw.acc_op;
            ctl.wb      = uw.wb;
            ctl.out_ld  = uw.out_ld & out_free;
            ctl.stage   = stage_reg;
            case (uw.jcond)
                JC_ZERO:
                begin
                    pc_next = (n_stages == '0) ? uw.jtarget : pc_reg + PC_W'(1);
                end
                JC_MORE:
                begin
                    stage_next = stage_reg + STAGE_W'(1);
                    pc_next    = last_stage ? pc_reg + PC_W'(1) : uw.jtarget;
                end
                JC_WAIT:
                begin
                    pc_next = uw.jtarget;
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= PC_DONE)
        else $error("program counter out of range");
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg != PC_CHECK && pc_reg != PC_DONE |-> NSTG_W'(stage_reg) < n_stages)
        else $error("stage index beyond active stages");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("transfer accepted while busy");
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg == PC_DONE && out_free && !start |=> !busy_reg)
        else $error("sequencer did not release after result load");
`endif

endmodule

// ===== rtl/cbq_datapath.sv =====
// ----------------------------------------------------------------------------
// cbq_datapath
// Coefficient memory, stage histories and the fractional saturating MAC.
// ----------------------------------------------------------------------------
module cbq_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cbq_pkg::ctl_t                     ctl,
    input  cbq_pkg::coef_wr_t                 cw,
    input  logic                              start,
    input  logic signed [cbq_pkg::DATA_W-1:0] sample_in,
    output logic signed [cbq_pkg::DATA_W-1:0] x_out
);
    import cbq_pkg::*;

    logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]    coef_vld_reg;
    logic signed [DATA_W-1:0] coef_raw_reg;
    logic                     rd_vld_reg;
    logic [CADDR_W-1:0]       rd_addr;
    logic signed [DATA_W-1:0] coef_q;

    logic signed [DATA_W-1:0] xh0_reg [MAX_STAGES];
    logic signed [DATA_W-1:0] xh1_reg [MAX_STAGES];
    logic signed [DATA_W-1:0] yh0_reg [MAX_STAGES];
    logic signed [DATA_W-1:0] yh1_reg [MAX_STAGES];
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] opd;

    logic signed [ACC_W-1:0]  prod_full;
    logic signed [ACC_W-1:0]  prod_dbl;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W:0]    sum;
    logic signed [DATA_W-1:0] y;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] PROD_FS = {2'b01, {(ACC_W-2){1'b0}}};

    assign rd_addr = coef_addr(ctl.stage, ctl.rd_slot);
    assign coef_q  = rd_vld_reg ? coef_raw_reg : '0;
    assign y       = acc_reg[ACC_W-1 -: DATA_W];
    assign x_out   = x_reg;

    always_ff @(posedge clk)
    begin
        if (cw.en)
        begin
            coef_mem[cw.addr] <= cw.data;
        end
        if (ctl.rd_en)
        begin
            coef_raw_reg <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cw.en)
            begin
                coef_vld_reg[cw.addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= coef_vld_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        case (ctl.mul_sel)
            OPD_X:   opd = x_reg;
            OPD_XH0: opd = xh0_reg[ctl.stage];
            OPD_XH1: opd = xh1_reg[ctl.stage];
            OPD_YH0: opd = yh0_reg[ctl.stage];
            OPD_YH1: opd = yh1_reg[ctl.stage];
            default: opd = '0;
        endcase
    end

    // -1 * -1 doubles past full scale
    assign prod_full = coef_q * opd;
    assign prod_dbl  = (prod_full == PROD_FS) ? ACC_MAX : (prod_full <<< 1);

    always_comb
    begin
        case (ctl.acc_op)
            ACC_ADD: sum = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
            ACC_SUB: sum = {acc_reg[ACC_W-1], acc_reg} - {prod_reg[ACC_W-1], prod_reg};
            default: sum = {prod_reg[ACC_W-1], prod_reg};
        endcase
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_dbl;
        end
        if (ctl.acc_op != ACC_NOP)
        begin
            acc_reg <= acc_next;
        end
        if (start)
        begin
            x_reg <= sample_in;
        end
        else if (ctl.wb)
        begin
            x_reg <= y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                xh0_reg[i] <= '0;
                xh1_reg[i] <= '0;
                yh0_reg[i] <= '0;
                yh1_reg[i] <= '0;
            end
        end
        else if (ctl.wb)
        begin
            xh1_reg[ctl.stage] <= xh0_reg[ctl.stage];
            xh0_reg[ctl.stage] <= x_reg;
            yh1_reg[ctl.stage] <= yh0_reg[ctl.stage];
            yh0_reg[ctl.stage] <= y;
        end
    end

endmodule

// ===== rtl/cascaded_biquad_iir_filter.sv =====
// Each sample runs through the single shared MAC, which executes the ten-step
// per-stage microprogram; s_tready stays low until its result is loaded, so no
// sample or coefficient transfer enters while one is in flight.
// Output register lets the next transfer enter while a result waits.
// Reset: histories and coefficients read as zero, stage_count returns to 2.
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Direct-form-I biquad cascade, Q15, microcoded shared MAC, APB config.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter
(
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample_in[15:0], coef_stage[18:16], coef_slot[21:19],
                                   // coef_value[37:22], zero[39:38]
    input  logic        s_tuser,   // req_type
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sample_out
);
    import cbq_pkg::*;

    logic [NSTG_W-1:0]        stage_count_reg;
    logic [NSTG_W-1:0]        n_stages;
    logic                     accept;
    logic                     start;
    logic                     busy;
    logic                     out_free;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic signed [DATA_W-1:0] x_out;
    logic [STAGE_W-1:0]       wr_stage;
    logic [SLOT_W-1:0]        wr_slot;
    ctl_t                     ctl;
    coef_wr_t                 cw;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_STAGE_COUNT) ? 32'(stage_count_reg) : '0;

    assign n_stages = (stage_count_reg > NSTG_W'(MAX_STAGES)) ? NSTG_W'(MAX_STAGES)
                                                             : stage_count_reg;

    assign s_tready = !busy;
    assign accept   = s_tvalid & s_tready;
    assign start    = accept & (s_tuser == REQ_FILTER);

    assign wr_stage = s_tdata[18:16];
    assign wr_slot  = s_tdata[21:19];
    assign cw.en    = accept & (s_tuser == REQ_COEF)
                      & (32'(wr_slot) < COEFS_PER_STAGE) & (32'(wr_stage) < MAX_STAGES);
    assign cw.addr  = coef_addr(wr_stage, wr_slot);
    assign cw.data  = s_tdata[37:22];

    assign out_free = !out_valid_reg | m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= STAGE_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_STAGE_COUNT)
        begin
            stage_count_reg <= pwdata[NSTG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_ld)
        begin
            out_data_reg <= x_out;
        end
    end

    cbq_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .n_stages (n_stages),
        .out_free (out_free),
        .ctl      (ctl),
        .busy     (busy)
    );

    cbq_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cw        (cw),
        .start     (start),
        .sample_in (s_tdata[15:0]),
        .x_out     (x_out)
    );

endmodule

// ===== tb/tb_cascaded_biquad_iir_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_iir_filter
// Sample and coefficient transfers go in on the input stream. Each filtered
// sample is checked in order against a Q15 direct-form-I cascade computed
// here, or a typed value for some directed items. The run covers several
// stage counts written over APB, and random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_iir_filter;

    import cbq_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_BAD_LO = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_BAD_MID = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_BAD_HI = 3'd7;
    localparam int DRAIN_CYCLES = 2 + 10 * MAX_STAGES + 8;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 145;

    typedef struct {
        logic        req;
        logic [15:0] smp;
        logic [2:0]  stg;
        logic [2:0]  slt;
        logic [15:0] val;
        bit          known;
        logic [15:0] typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // sample_in, coef_stage, coef_slot, coef_value, zero pad
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // sample_out

    int          coef_mem [0:COEF_DEPTH-1];
    int          x_hist [0:2*MAX_STAGES-1];
    int          y_hist [0:2*MAX_STAGES-1];
    logic [3:0]  active_stages;
    logic [15:0] pending_outputs [$];
    logic [15:0] want;
    int          fail_count;
    bit          idle_en;
    int          rx_stall;
    stim_row_t   directed [0:22];
    logic [3:0]  phase_cnt [0:NUM_PHASES-1];

    cascaded_biquad_iir_filter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mac_step(input longint acc, input int a, input int b,
                                        input bit neg);
        longint p;
        p = sat32(longint'(a) * longint'(b) * 2);
        return sat32(neg ? acc - p : acc + p);
    endfunction

    function automatic logic [15:0] cascade_output(input logic [15:0] smp);
        int                 n;
        int                 x;
        int                 cb;
        longint             acc;
        logic signed [15:0] y;
        n = (active_stages > MAX_STAGES) ? MAX_STAGES : int'(active_stages);
        x = int'($signed(smp));
        for (int s = 0; s < n; s++)
        begin
            cb = s * COEFS_PER_STAGE;
            acc = 0;
            acc = mac_step(acc, coef_mem[cb + 0], x, 1'b0);
            acc = mac_step(acc, coef_mem[cb + 1], x_hist[2*s], 1'b0);
            acc = mac_step(acc, coef_mem[cb + 1], x_hist[2*s], 1'b0);
            acc = mac_step(acc, coef_mem[cb + 2], x_hist[2*s+1], 1'b0);
            acc = mac_step(acc, coef_mem[cb + 3], y_hist[2*s], 1'b1);
            acc = mac_step(acc, coef_mem[cb + 3], y_hist[2*s], 1'b1);
            acc = mac_step(acc, coef_mem[cb + 4], y_hist[2*s+1], 1'b1);
            y = acc[31:16];
            y_hist[2*s+1] = y_hist[2*s];
            y_hist[2*s] = int'(y);
            x_hist[2*s+1] = x_hist[2*s];
            x_hist[2*s] = x;
            x = int'(y);
        end
        return x[15:0];
    endfunction

    // half small values so the filters stay out of saturation some of the time
    function automatic logic [15:0] rand_q15(input int span);
        int k;
        k = $urandom_range(0, 7);
        if (k == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (k < 5)
            return 16'($signed($urandom_range(0, 2 * span)) - span);
        return 16'($urandom());
    endfunction

    task automatic push_item(input logic req, input logic [15:0] smp, input logic [2:0] stg,
                             input logic [2:0] slt, input logic [15:0] val,
                             input bit known, input logic [15:0] typed);
        logic [15:0] y;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, val, slt, stg, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req == REQ_COEF)
        begin
            if (slt <= SLOT_B2)
                coef_mem[int'(stg) * COEFS_PER_STAGE + int'(slt)] = int'($signed(val));
        end
        else
        begin
            y = cascade_output(smp);
            pending_outputs.push_back(known ? typed : y);
        end
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_stage_count(input logic [3:0] cnt);
        logic [31:0] w;
        w = $urandom();
        w[3:0] = cnt;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_STAGE_COUNT);
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_stages = cnt;
    endtask

    // result side: random stall bursts on m_tready
    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            rx_stall <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: unexpected sample_out transfer, got %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %h, got %h",
                             $time, want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** cascaded_biquad_iir_filter: FAILED **");
        $finish;
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_FILTER;
        m_tready = 1'b1;
        rx_stall = 0;
        idle_en  = 1'b1;
        fail_count = 0;
        active_stages = STAGE_COUNT_RST;
        for (int i = 0; i < COEF_DEPTH; i++)
            coef_mem[i] = 0;
        for (int i = 0; i < 2 * MAX_STAGES; i++)
        begin
            x_hist[i] = 0;
            y_hist[i] = 0;
        end

        directed = '{
            '{REQ_FILTER, 16'h7FFF, 3'd0, SLOT_A0, 16'h0000, 1'b1, 16'h0000},
            '{REQ_FILTER, 16'h8000, 3'd0, SLOT_A0, 16'h0000, 1'b1, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_A0, 16'h8000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'hFFFF, 3'd1, SLOT_A0, 16'h7FFF, 1'b0, 16'h0000},
            // -1 * -1 saturates, then the second stage scales by 0x7FFF
            '{REQ_FILTER, 16'h8000, 3'd7, SLOT_B2, 16'hFFFF, 1'b1, 16'h7FFE},
            '{REQ_COEF,   16'h1234, 3'd0, SLOT_BAD_LO, 16'h1111, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_BAD_HI, 16'h2222, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h4000, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_A1, 16'h7FFF, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_A2, 16'h8000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_B1, 16'h4000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd0, SLOT_B2, 16'h8000, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h7FFF, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h8000, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h0001, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd1, SLOT_B1, 16'h8000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd1, SLOT_B2, 16'h7FFF, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd7, SLOT_B2, 16'h7FFF, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd7, SLOT_A0, 16'h8000, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'hFFFF, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h1234, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000},
            '{REQ_COEF,   16'h0000, 3'd2, SLOT_BAD_MID, 16'h5555, 1'b0, 16'h0000},
            '{REQ_FILTER, 16'h8000, 3'd0, SLOT_A0, 16'h0000, 1'b0, 16'h0000}
        };

        phase_cnt = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd0, 4'd6, 4'd0, 4'd2};
        phase_cnt[6] = 4'($urandom_range(0, 15));
        phase_cnt[8] = 4'($urandom_range(1, 8));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            push_item(directed[i].req, directed[i].smp, directed[i].stg, directed[i].slt,
                      directed[i].val, directed[i].known, directed[i].typed);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            repeat (DRAIN_CYCLES)
                @(posedge clk);
            idle_en = (ph != NUM_PHASES - 1) && (ph != 4);
            set_stage_count(phase_cnt[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                push_item(($urandom_range(0, 99) < 18) ? REQ_COEF : REQ_FILTER,
                          rand_q15(2048), 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                     : 3'($urandom_range(5, 7)),
                          rand_q15(8192), 1'b0, 16'h0000);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("** cascaded_biquad_iir_filter: PASSED **");
        else
            $display("** cascaded_biquad_iir_filter: FAILED **");
        $finish;
    end

endmodule
